/* design/sfv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sfv_pkg;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned MAC_BYTES    = 3;
  localparam int unsigned FRESH_WINDOW = 16;
  localparam int unsigned IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [31:0] FRESH_HI_MASK = 32'hFFFF_FF00;
  localparam logic [31:0] FRESH_WRAP    = 32'h0000_0100;

  // register indexes of the configuration port
  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_SKIP_MAC = 3'd2;
  localparam logic [2:0] REG_SKIP_FR  = 3'd3;
  localparam logic [2:0] REG_STRIP    = 3'd4;

  localparam logic OP_VERIFY = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_EXTENDED  = 3'd1,
    V_UNKNOWN   = 3'd2,
    V_BAD_LEN   = 3'd3,
    V_FRESHNESS = 3'd4,
    V_MAC       = 3'd5,
    V_LOADED    = 3'd6
  } sfv_verdict_e;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  entry_index;
    logic [28:0] frame_id;
    logic        extended_flag;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_payload;
    logic [10:0] assoc_id;
    logic [2:0]  assoc_plain_len;
    logic [31:0] assoc_fresh_init;
    logic        assoc_valid;
  } sfv_in_t;

  typedef struct packed {
    sfv_verdict_e verdict;
    logic         forward;
    logic [10:0]  out_id;
    logic [3:0]   out_dlc;
    logic [63:0]  out_payload;
  } sfv_out_t;

  typedef struct packed {
    logic [10:0] id;
    logic [2:0]  plain_len;
    logic [31:0] fresh;
  } sfv_entry_t;

endpackage
`default_nettype wire

/* design/sfv_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sfv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* design/sfv_aes.sv */
`timescale 1ns / 1ps
`default_nettype none
module sfv_aes (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] key_i,
  input  wire logic [127:0] block_i,
  output logic              done_o,
  output logic      [127:0] out_o
);

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [3:0] LAST_ROUND = 4'd10;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_of(input logic [127:0] v, input int b);
    return v[127-8*b -: 8];
  endfunction

  logic [127:0] state_q, rk_q;
  logic [7:0]   rcon_q;
  logic [3:0]   rnd_q;
  logic         busy_q;

  logic [127:0] rk_next, sub_s, shr_s, mix_s, round_out;
  logic [31:0]  last_w, tw, w0, w1, w2, w3;
  logic [7:0]   a0, a1, a2, a3;

  // next round key from the current one
  always_comb begin
    last_w = rk_q[31:0];
    tw = {SBOX[last_w[23:16]] ^ rcon_q, SBOX[last_w[15:8]], SBOX[last_w[7:0]],
          SBOX[last_w[31:24]]};
    w0 = rk_q[127:96] ^ tw;
    w1 = rk_q[95:64] ^ w0;
    w2 = rk_q[63:32] ^ w1;
    w3 = rk_q[31:0] ^ w2;
    rk_next = {w0, w1, w2, w3};
  end

  // one round: sub bytes, shift rows, mix columns (not in the last round), add key
  always_comb begin
    a0 = '0; a1 = '0; a2 = '0; a3 = '0;
    for (int b = 0; b < 16; b++) begin
      sub_s[127-8*b -: 8] = SBOX[byte_of(state_q, b)];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        shr_s[127-8*(j+4*c) -: 8] = byte_of(sub_s, j + 4*((c + j) % 4));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(shr_s, 4*c);
      a1 = byte_of(shr_s, 4*c+1);
      a2 = byte_of(shr_s, 4*c+2);
      a3 = byte_of(shr_s, 4*c+3);
      mix_s[127-8*(4*c) -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mix_s[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mix_s[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mix_s[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    round_out = ((rnd_q == LAST_ROUND) ? shr_s : mix_s) ^ rk_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      rnd_q  <= '0;
      rcon_q <= 8'h01;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 4'd1;
        rcon_q <= 8'h01;
      end else if (busy_q) begin
        rnd_q  <= rnd_q + 4'd1;
        rcon_q <= xtime(rcon_q);
        if (rnd_q == LAST_ROUND) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      state_q <= block_i ^ key_i;
      rk_q    <= key_i;
    end else if (busy_q) begin
      state_q <= round_out;
      rk_q    <= rk_next;
    end
  end

  assign out_o = state_q;

endmodule
`default_nettype wire

/* design/secoc_frame_verifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// secured classic can frame verifier. a load beat writes one slot of the association
// table and a verify beat looks its standard id up, checks the length, extends the
// one-byte freshness value against the stored expected value and compares the
// truncated aes-cmac; a passing frame advances its freshness value and is forwarded
// plain or secured. the table lives in a one-port-read, one-port-write ram with
// valid bits in flops, so reset needs no clearing pass. loads and extended frames
// are accepted and then pushed; a verify beat walks the table one entry a cycle
// and, if it reaches the mac compare, then runs the iterative aes core twice, once
// for the subkey and once for the tag. the input stays closed from the accept
// through the scan, the check, any aes runs and the push, plus any output stall.
// one item is in work at a time; a finished result waits in the output register
// while the next beat is taken.
module secoc_frame_verifier
  import sfv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire sfv_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output sfv_out_t         out_data_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [5:0]  paddr_i,
  input  wire logic [63:0] pwdata_i,
  output logic      [63:0] prdata_o,
  output logic             pready_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_AES_L = 3'd3;
  localparam logic [2:0] S_AES_T = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  localparam int unsigned EW = $bits(sfv_entry_t);

  // configuration registers
  logic [63:0] key_high_q, key_low_q;
  logic        skip_mac_q, skip_fresh_q, strip_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q   <= '0;
      key_low_q    <= '0;
      skip_mac_q   <= 1'b0;
      skip_fresh_q <= 1'b0;
      strip_q      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr_i[5:3])
        REG_KEY_HIGH: key_high_q   <= pwdata_i;
        REG_KEY_LOW:  key_low_q    <= pwdata_i;
        REG_SKIP_MAC: skip_mac_q   <= pwdata_i[0];
        REG_SKIP_FR:  skip_fresh_q <= pwdata_i[0];
        REG_STRIP:    strip_q      <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[5:3])
      REG_KEY_HIGH: prdata_o = key_high_q;
      REG_KEY_LOW:  prdata_o = key_low_q;
      REG_SKIP_MAC: prdata_o = {63'd0, skip_mac_q};
      REG_SKIP_FR:  prdata_o = {63'd0, skip_fresh_q};
      REG_STRIP:    prdata_o = {63'd0, strip_q};
      default:      prdata_o = '0;
    endcase
  end

  // control state
  logic [2:0]       state_q, state_d;
  logic [IDX_W:0]   scan_q, scan_d;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  sfv_in_t          item_q;
  sfv_entry_t       ent_q, ent_d;
  logic [IDX_W-1:0] ent_idx_q, ent_idx_d;
  logic [31:0]      full_q, full_d;
  sfv_out_t         res_q, res_d, out_q;

  // table ram
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  sfv_entry_t       ram_wdata, ram_rdata;
  logic [EW-1:0]    ram_rdata_raw;

  sfv_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );
  assign ram_rdata = sfv_entry_t'(ram_rdata_raw);

  // aes core
  logic         aes_start, aes_done;
  logic [127:0] aes_key, aes_block, aes_out;

  assign aes_key = {key_high_q, key_low_q};

  sfv_aes u_aes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aes_start),
    .key_i   (aes_key),
    .block_i (aes_block),
    .done_o  (aes_done),
    .out_o   (aes_out)
  );

  logic in_acc, out_acc;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_acc     = out_valid_q & out_ready_i;

  // lookup compare on the entry read in the previous cycle
  logic hit;
  assign hit = rd_vld_q && valid_q[rd_idx_q] && (ram_rdata.id == item_q.frame_id[10:0]);

  // length and freshness checks on the matched entry
  logic [3:0]  need_len;
  logic        len_bad, fresh_bad;
  logic [7:0]  fresh_byte;
  logic [31:0] full_c, full_sel, full_acc;
  logic [63:0] pay_sh, mac_sh;

  always_comb begin
    need_len   = {1'b0, ent_q.plain_len} + 4'd1 + 4'(MAC_BYTES);
    len_bad    = (need_len > 4'd8) || (item_q.frame_dlc != need_len);
    pay_sh     = item_q.frame_payload >> {ent_q.plain_len, 3'b000};
    fresh_byte = pay_sh[7:0];
    full_c     = (ent_q.fresh & FRESH_HI_MASK) | {24'd0, fresh_byte};
    if (full_c < ent_q.fresh) begin
      full_c = full_c + FRESH_WRAP;
    end
    fresh_bad = !skip_fresh_q && ((full_c - ent_q.fresh) >= 32'(FRESH_WINDOW));
    full_sel  = skip_fresh_q ? ent_q.fresh : full_c;
    full_acc  = (state_q == S_CHECK) ? full_sel : full_q;
  end

  // cmac subkeys and the single padded block
  logic [127:0] k1, k2, msg_blk;
  logic [7:0]   pb;

  always_comb begin
    k1 = {aes_out[126:0], 1'b0} ^ (aes_out[127] ? 128'h87 : 128'h0);
    k2 = {k1[126:0], 1'b0} ^ (k1[127] ? 128'h87 : 128'h0);
    msg_blk[127:64] = {16'd0, 5'd0, item_q.frame_id[10:0], full_q};
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < ent_q.plain_len) begin
        pb = item_q.frame_payload[8*i +: 8];
      end else if (3'(i) == ent_q.plain_len) begin
        pb = 8'h80;
      end else begin
        pb = 8'h00;
      end
      msg_blk[63-8*i -: 8] = pb;
    end
  end

  // truncated tag compare
  logic mac_bad;
  always_comb begin
    mac_sh  = pay_sh >> 8;
    mac_bad = 1'b0;
    for (int i = 0; i < MAC_BYTES; i++) begin
      mac_bad = mac_bad | (mac_sh[8*i +: 8] != aes_out[127-8*i -: 8]);
    end
  end

  // forwarded frame for a passing item
  sfv_out_t pass_res;
  logic [63:0] strip_pay;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      strip_pay[8*i +: 8] = (3'(i) < ent_q.plain_len) ? item_q.frame_payload[8*i +: 8]
                                                      : 8'h00;
    end
    pass_res.verdict     = V_OK;
    pass_res.forward     = 1'b1;
    pass_res.out_id      = item_q.frame_id[10:0];
    pass_res.out_dlc     = strip_q ? {1'b0, ent_q.plain_len} : item_q.frame_dlc;
    pass_res.out_payload = strip_q ? strip_pay : item_q.frame_payload;
  end

  function automatic sfv_out_t reject(input sfv_verdict_e v);
    sfv_out_t r;
    r = '0;
    r.verdict = v;
    return r;
  endfunction

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    valid_d     = valid_q;
    ent_d       = ent_q;
    ent_idx_d   = ent_idx_q;
    full_d      = full_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_acc;
    ram_we      = 1'b0;
    ram_waddr   = ent_idx_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = scan_q[IDX_W-1:0];
    aes_start   = 1'b0;
    aes_block   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_LOAD) begin
            // slots beyond the table are dropped, still reported as loaded
            if (32'(in_data_i.entry_index) < ENTRIES) begin
              ram_we    = 1'b1;
              ram_waddr = IDX_W'(in_data_i.entry_index);
              ram_wdata = '{id: in_data_i.assoc_id, plain_len: in_data_i.assoc_plain_len,
                            fresh: in_data_i.assoc_fresh_init};
              valid_d[IDX_W'(in_data_i.entry_index)] = in_data_i.assoc_valid;
            end
            res_d   = reject(V_LOADED);
            state_d = S_PUSH;
          end else if (in_data_i.extended_flag) begin
            res_d   = reject(V_EXTENDED);
            state_d = S_PUSH;
          end else begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read issued a cycle, the previous read checked; lowest index wins
        ram_re = !hit && (scan_q < (IDX_W+1)'(ENTRIES));
        if (ram_re) begin
          scan_d = scan_q + 1'b1;
        end
        if (hit) begin
          ent_d     = ram_rdata;
          ent_idx_d = rd_idx_q;
          state_d   = S_CHECK;
        end else if (!rd_vld_q && (scan_q == (IDX_W+1)'(ENTRIES))) begin
          res_d   = reject(V_UNKNOWN);
          state_d = S_PUSH;
        end
      end
      S_CHECK: begin
        full_d = full_sel;
        if (len_bad) begin
          res_d   = reject(V_BAD_LEN);
          state_d = S_PUSH;
        end else if (fresh_bad) begin
          res_d   = reject(V_FRESHNESS);
          state_d = S_PUSH;
        end else if (skip_mac_q) begin
          ram_we    = 1'b1;
          ram_wdata = '{id: ent_q.id, plain_len: ent_q.plain_len, fresh: full_acc + 32'd1};
          res_d     = pass_res;
          state_d   = S_PUSH;
        end else begin
          // subkey source: encryption of the zero block
          aes_start = 1'b1;
          state_d   = S_AES_L;
        end
      end
      S_AES_L: begin
        if (aes_done) begin
          aes_start = 1'b1;
          aes_block = msg_blk ^ k2;
          state_d   = S_AES_T;
        end
      end
      S_AES_T: begin
        if (aes_done) begin
          if (mac_bad) begin
            res_d = reject(V_MAC);
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{id: ent_q.id, plain_len: ent_q.plain_len, fresh: full_acc + 32'd1};
            res_d     = pass_res;
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      rd_vld_q    <= ram_re;
      rd_idx_q    <= scan_q[IDX_W-1:0];
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    ent_q     <= ent_d;
    ent_idx_q <= ent_idx_d;
    full_q    <= full_d;
    res_q     <= res_d;
    if ((state_q == S_PUSH) && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  // a forwarded beat always carries the ok verdict
  a_fwd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.forward |-> out_data_o.verdict == V_OK)
    else $error("forwarded beat without ok verdict");

  // a dropped beat carries no frame
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.forward |->
      (out_data_o.out_payload == '0) && (out_data_o.out_dlc == '0) &&
      (out_data_o.out_id == '0))
    else $error("dropped beat carries frame data");

  // the aes core only finishes while the sequencer waits on it
  a_aes_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_done |-> (state_q == S_AES_L) || (state_q == S_AES_T))
    else $error("aes result outside a wait state");

  // table writes never overlap a lookup
  a_no_wr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q != S_SCAN)
    else $error("table write during lookup");

  // a read issued in a lookup is checked in the next cycle
  a_scan_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> rd_vld_q && (state_q == S_SCAN))
    else $error("lookup read lost");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import sfv_pkg::*;

  // aes forward s-box, used by the tag predictor
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // how a directed row turns into a beat
  typedef enum logic [1:0] {ROW_RAW, ROW_FRAME} row_kind_e;
  // defects put into an otherwise well-formed secured frame
  typedef enum logic [1:0] {FLAW_NONE, FLAW_MAC, FLAW_STALE, FLAW_DLC} flaw_e;

  typedef struct {
    row_kind_e    kind;
    sfv_in_t      beat;
    int           slot;
    int           delta;
    flaw_e        flaw;
    bit           typed;
    sfv_verdict_e verdict;
  } row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sfv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sfv_out_t out_data;
  logic     psel = 1'b0;
  logic     penable = 1'b0;
  logic     pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  secoc_frame_verifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the block: settings and association table
  logic [63:0] key_hi_m, key_lo_m;
  logic        skip_mac_m, skip_fresh_m, strip_m;
  logic        tbl_valid [ENTRIES];
  logic [10:0] tbl_id    [ENTRIES];
  logic [2:0]  tbl_plen  [ENTRIES];
  logic [31:0] tbl_fresh [ENTRIES];

  sfv_out_t verdict_q [$];   // results still owed by the block
  int       errors = 0;
  int       beats_sent = 0;
  int       tx_idle = 35;    // percent of cycles the sender holds off
  int       rx_idle = 62;    // percent of cycles the receiver stalls

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // aes-128 encryption, byte 0 in the top bits of key and block
  function automatic logic [127:0] aes_encrypt(logic [127:0] key, logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = w[0];
        w[0] = SBOX[w[1]] ^ RCON[i/16-1];
        w[1] = SBOX[w[2]];
        w[2] = SBOX[w[3]];
        w[3] = SBOX[f];
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
      // shift rows
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[j+4*c] = s[j+4*((c+j)%4)];
      if (r < 10) begin
        // mix columns
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          s[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
          s[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
          s[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
          s[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
      end else begin
        for (int i = 0; i < 16; i++) s[i] = t[i];
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  // truncated cmac tag over id, full freshness value and plain bytes;
  // the message never fills a block, so the k2 padding path always applies
  function automatic logic [8*MAC_BYTES-1:0] secoc_tag(logic [10:0] id, logic [31:0] fv,
                                                       logic [63:0] pay, int plen);
    logic [127:0] key, lsub, k1, k2, blk, tag;
    int len;
    key  = {key_hi_m, key_lo_m};
    lsub = aes_encrypt(key, '0);
    k1   = {lsub[126:0], 1'b0} ^ (lsub[127] ? 128'h87 : 128'h0);
    k2   = {k1[126:0], 1'b0} ^ (k1[127] ? 128'h87 : 128'h0);
    blk  = '0;
    blk[127:64] = {16'h0, 5'h0, id, fv};
    for (int i = 0; i < plen; i++) blk[63-8*i -: 8] = pay[8*i +: 8];
    len = 8 + plen;
    blk[127-8*len -: 8] = 8'h80;
    tag = aes_encrypt(key, blk ^ k2);
    return tag[127 -: 8*MAC_BYTES];
  endfunction

  // lowest valid slot holding this id, -1 if none
  function automatic int lookup_slot(logic [10:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  // expected result of one accepted beat; advances the mirrored table
  function automatic sfv_out_t check_frame(sfv_in_t x);
    sfv_out_t   o;
    int         hit, plen;
    logic [10:0] id;
    logic [31:0] ev, fv;
    logic [7:0]  rx_fresh;
    logic [8*MAC_BYTES-1:0] tag;
    logic [63:0] plain;
    o = '0;
    if (x.opcode == OP_LOAD) begin
      if (x.entry_index < ENTRIES) begin
        tbl_valid[x.entry_index] = x.assoc_valid;
        tbl_id[x.entry_index]    = x.assoc_id;
        tbl_plen[x.entry_index]  = x.assoc_plain_len;
        tbl_fresh[x.entry_index] = x.assoc_fresh_init;
      end
      o.verdict = V_LOADED;
      return o;
    end
    if (x.extended_flag) begin
      o.verdict = V_EXTENDED;
      return o;
    end
    id  = x.frame_id[10:0];
    hit = lookup_slot(id);
    if (hit < 0) begin
      o.verdict = V_UNKNOWN;
      return o;
    end
    plen = tbl_plen[hit];
    if (plen + 1 + MAC_BYTES > 8 || x.frame_dlc != plen + 1 + MAC_BYTES) begin
      o.verdict = V_BAD_LEN;
      return o;
    end
    ev = tbl_fresh[hit];
    if (!skip_fresh_m) begin
      rx_fresh = x.frame_payload[8*plen +: 8];
      fv = (ev & FRESH_HI_MASK) | {24'h0, rx_fresh};
      if (fv < ev) fv = fv + FRESH_WRAP;
      if (fv - ev >= FRESH_WINDOW) begin
        o.verdict = V_FRESHNESS;
        return o;
      end
    end else begin
      fv = ev;
    end
    if (!skip_mac_m) begin
      tag = secoc_tag(id, fv, x.frame_payload, plen);
      for (int i = 0; i < MAC_BYTES; i++)
        if (x.frame_payload[8*(plen+1+i) +: 8] != tag[8*(MAC_BYTES-1-i) +: 8]) begin
          o.verdict = V_MAC;
          return o;
        end
    end
    tbl_fresh[hit] = fv + 32'd1;
    o.verdict = V_OK;
    o.forward = 1'b1;
    o.out_id  = id;
    if (strip_m) begin
      plain = '0;
      for (int i = 0; i < plen; i++) plain[8*i +: 8] = x.frame_payload[8*i +: 8];
      o.out_dlc     = 4'(plen);
      o.out_payload = plain;
    end else begin
      o.out_dlc     = x.frame_dlc;
      o.out_payload = x.frame_payload;
    end
    return o;
  endfunction

  // random filler for every field; callers overwrite what matters
  function automatic sfv_in_t noise_beat();
    sfv_in_t x;
    x.opcode           = OP_VERIFY;
    x.entry_index      = 4'($urandom);
    x.frame_id         = 29'({$urandom, $urandom} >> 3);
    x.extended_flag    = 1'b0;
    x.frame_dlc        = 4'($urandom_range(0, 8));
    x.frame_payload    = {$urandom, $urandom};
    x.assoc_id         = 11'($urandom);
    x.assoc_plain_len  = 3'($urandom);
    x.assoc_fresh_init = $urandom;
    x.assoc_valid      = 1'($urandom);
    return x;
  endfunction

  function automatic sfv_in_t load_beat(int idx, logic [10:0] id, logic [2:0] plen,
                                        logic [31:0] fv, logic valid);
    sfv_in_t x;
    x = noise_beat();
    x.opcode           = OP_LOAD;
    x.entry_index      = 4'(idx);
    x.assoc_id         = id;
    x.assoc_plain_len  = plen;
    x.assoc_fresh_init = fv;
    x.assoc_valid      = valid;
    return x;
  endfunction

  // secured frame for the entry that an id lookup from this slot would hit
  function automatic sfv_in_t secured_frame(int slot, int delta, flaw_e flaw);
    sfv_in_t x;
    int hit, plen, mb;
    logic [31:0] fv;
    logic [8*MAC_BYTES-1:0] tag;
    x = noise_beat();
    hit  = lookup_slot(tbl_id[slot]);
    if (hit < 0) hit = slot;
    plen = tbl_plen[hit];
    if (flaw == FLAW_STALE) delta = $urandom_range(FRESH_WINDOW, 255);
    fv = skip_fresh_m ? tbl_fresh[hit] : tbl_fresh[hit] + 32'(delta);
    x.frame_id[10:0] = tbl_id[hit];
    x.frame_dlc      = 4'((plen + 1 + MAC_BYTES > 8) ? 8 : plen + 1 + MAC_BYTES);
    if (plen + 1 + MAC_BYTES <= 8) begin
      x.frame_payload[8*plen +: 8] = fv[7:0];
      tag = secoc_tag(tbl_id[hit], fv, x.frame_payload, plen);
      for (int i = 0; i < MAC_BYTES; i++)
        x.frame_payload[8*(plen+1+i) +: 8] = tag[8*(MAC_BYTES-1-i) +: 8];
      if (flaw == FLAW_MAC) begin
        mb = plen + 1 + $urandom_range(0, MAC_BYTES - 1);
        x.frame_payload[8*mb + $urandom_range(0, 7)] ^= 1'b1;
      end
    end
    if (flaw == FLAW_DLC) x.frame_dlc = x.frame_dlc ^ 4'(1 + $urandom_range(0, 6));
    return x;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("tb: mismatch %s want %h got %h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // send one beat; the previous one (if any) was accepted at the current edge
  task automatic send_beat(sfv_in_t x, bit typed, sfv_verdict_e verdict);
    sfv_out_t e;
    if (in_valid && $urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk_i); while (!in_ready);
    e = check_frame(x);
    if (typed) begin
      // typed verdicts carry nothing else
      e = '0;
      e.verdict = verdict;
    end
    verdict_q.push_back(e);
    beats_sent++;
    // sender holds off in three stretches: light, heavy, none
    if (beats_sent < 560) begin
      tx_idle = 35; rx_idle = 62;
    end else if (beats_sent < 1100) begin
      tx_idle = 62; rx_idle = 35;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
  endtask

  // drain: stop sending, wait for every owed result and the engine to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KEY_HIGH: key_hi_m     = val;
      REG_KEY_LOW:  key_lo_m     = val;
      REG_SKIP_MAC: skip_mac_m   = val[0];
      REG_SKIP_FR:  skip_fresh_m = val[0];
      REG_STRIP:    strip_m      = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(logic [63:0] kh, logic [63:0] kl, logic sm, logic sf, logic st);
    reg_write(REG_KEY_HIGH, kh);
    reg_write(REG_KEY_LOW, kl);
    reg_write(REG_SKIP_MAC, {63'h0, sm});
    reg_write(REG_SKIP_FR, {63'h0, sf});
    reg_write(REG_STRIP, {63'h0, st});
  endtask

  // receiver stalls at random
  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= rx_idle);

  // result checker
  always @(posedge clk_i) begin
    sfv_out_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report("unexpected result", '0, 64'(out_data.verdict));
      end else begin
        e = verdict_q.pop_front();
        if (out_data.verdict != e.verdict)
          report("verdict", 64'(e.verdict), 64'(out_data.verdict));
        if (out_data.forward != e.forward)
          report("forward", 64'(e.forward), 64'(out_data.forward));
        if (out_data.out_id != e.out_id)
          report("out_id", 64'(e.out_id), 64'(out_data.out_id));
        if (out_data.out_dlc != e.out_dlc)
          report("out_dlc", 64'(e.out_dlc), 64'(out_data.out_dlc));
        if (out_data.out_payload != e.out_payload)
          report("out_payload", e.out_payload, out_data.out_payload);
      end
    end
  end

  initial begin
    row_t      rows [$];
    row_t      rw;
    sfv_in_t   x;
    int        pick, slot;
    logic [63:0] keys [3];

    // reset state of the mirror
    key_hi_m = '0; key_lo_m = '0;
    skip_mac_m = 1'b0; skip_fresh_m = 1'b0; strip_m = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_id[i] = '0; tbl_plen[i] = '0; tbl_fresh[i] = '0;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, defaults after reset (zero key, both checks, stripped)
    rw = '{ROW_RAW, '0, 0, 0, FLAW_NONE, 1'b1, V_UNKNOWN};
    rw.beat = noise_beat(); rw.beat.frame_id = 29'h0000_0123; rows.push_back(rw);
    rw.beat = noise_beat(); rw.beat.extended_flag = 1'b1;
    rw.beat.frame_id = '1; rw.verdict = V_EXTENDED; rows.push_back(rw);
    rw.verdict = V_LOADED;
    rw.beat = load_beat(0, 11'h123, 3'd4, 32'h0, 1'b1); rows.push_back(rw);
    // near the top of the 32-bit range so the extension wraps
    rw.beat = load_beat(15, 11'h7FF, 3'd0, 32'hFFFF_FFF8, 1'b1); rows.push_back(rw);
    // same id in a higher slot: the lower slot must win
    rw.beat = load_beat(3, 11'h123, 3'd2, 32'h0000_01F0, 1'b1); rows.push_back(rw);
    // plain length too long for any classic frame
    rw.beat = load_beat(7, 11'h055, 3'd7, '1, 1'b1); rows.push_back(rw);
    rw.verdict = V_BAD_LEN;
    rw.beat = noise_beat(); rw.beat.frame_id = 29'h1FFF_F855;
    rw.beat.frame_dlc = 4'd8; rows.push_back(rw);
    rw.beat = noise_beat(); rw.beat.frame_id = 29'h0000_0123;
    rw.beat.frame_dlc = 4'd5; rows.push_back(rw);
    rw.beat = noise_beat(); rw.beat.frame_id = 29'h0000_0123;
    rw.beat.frame_dlc = 4'd0; rows.push_back(rw);
    rw.typed = 1'b0; rw.kind = ROW_FRAME;
    rw.slot = 0;  rw.delta = 0;  rw.flaw = FLAW_NONE;  rows.push_back(rw);
    rw.slot = 0;  rw.delta = 15; rw.flaw = FLAW_NONE;  rows.push_back(rw);
    rw.slot = 0;  rw.delta = 16; rw.flaw = FLAW_NONE;  rows.push_back(rw);
    rw.slot = 0;  rw.delta = 0;  rw.flaw = FLAW_STALE; rows.push_back(rw);
    rw.slot = 0;  rw.delta = 1;  rw.flaw = FLAW_MAC;   rows.push_back(rw);
    rw.slot = 15; rw.delta = 10; rw.flaw = FLAW_NONE;  rows.push_back(rw);
    rw.slot = 15; rw.delta = 0;  rw.flaw = FLAW_NONE;  rows.push_back(rw);
    rw.slot = 15; rw.delta = 0;  rw.flaw = FLAW_DLC;   rows.push_back(rw);
    // clearing slot 0 uncovers slot 3, whose low byte sits below the received one
    rw.kind = ROW_RAW; rw.typed = 1'b1; rw.verdict = V_LOADED;
    rw.beat = load_beat(0, 11'h123, 3'd4, 32'h0, 1'b0); rows.push_back(rw);
    rw.kind = ROW_FRAME; rw.typed = 1'b0;
    rw.slot = 3; rw.delta = 15; rw.flaw = FLAW_NONE; rows.push_back(rw);
    rw.slot = 3; rw.delta = 0;  rw.flaw = FLAW_NONE; rows.push_back(rw);
    rw.kind = ROW_RAW; rw.typed = 1'b1; rw.verdict = V_UNKNOWN;
    rw.beat = noise_beat(); rw.beat.frame_id = 29'h1FFF_F800; rows.push_back(rw);

    foreach (rows[i]) begin
      x = (rows[i].kind == ROW_FRAME) ?
          secured_frame(rows[i].slot, rows[i].delta, rows[i].flaw) : rows[i].beat;
      send_beat(x, rows[i].typed, rows[i].verdict);
    end

    // random part: eight settings, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      keys[0] = {$urandom, $urandom};
      keys[1] = {$urandom, $urandom};
      keys[2] = (ph == 1) ? '1 : (ph == 5) ? '0 : keys[1];
      set_mode((ph == 1) ? '1 : (ph == 5) ? '0 : keys[0], keys[2],
               ph == 2 || ph == 4, ph == 3 || ph == 4,
               !(ph == 1 || ph == 4 || ph == 6));
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        slot = $urandom_range(0, ENTRIES - 1);
        if (lookup_slot(tbl_id[slot]) < 0) begin
          // favor short plain lengths so most frames can be carried
          pick = $urandom_range(99);
          x = load_beat(slot, 11'($urandom),
                        (pick < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom),
                        $urandom, pick < 92);
        end else if (pick < 8) begin
          x = load_beat(int'($urandom_range(0, 15)), 11'($urandom),
                        (pick < 6) ? 3'($urandom_range(0, 4)) : 3'($urandom),
                        $urandom, pick != 0);
        end else if (pick < 68) begin
          x = secured_frame(slot, $urandom_range(0, FRESH_WINDOW - 1), FLAW_NONE);
        end else if (pick < 75) begin
          x = secured_frame(slot, 0, FLAW_MAC);
        end else if (pick < 82) begin
          x = secured_frame(slot, 0, FLAW_STALE);
        end else if (pick < 86) begin
          x = secured_frame(slot, 0, FLAW_DLC);
        end else if (pick < 90) begin
          x = noise_beat();
          x.extended_flag = 1'b1;
        end else begin
          x = noise_beat();
          if (pick < 95) x.frame_id[10:0] = tbl_id[slot];
        end
        send_beat(x, 1'b0, V_OK);
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
